### hdl/svv_pkg.sv
// shared types and constants for the semantic version string validator
`default_nettype none

package svv_pkg;

    localparam int MAX_LEN = 32;
    localparam int CNT_W   = $clog2(MAX_LEN + 2);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_Z  = 8'h5A;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_Z  = 8'h7A;

    localparam logic [2:0] PH_MAJOR = 3'd0;
    localparam logic [2:0] PH_MINOR = 3'd1;
    localparam logic [2:0] PH_PATCH = 3'd2;
    localparam logic [2:0] PH_PRE   = 3'd3;
    localparam logic [2:0] PH_BUILD = 3'd4;

    typedef struct packed {
        logic [2:0]       phase;
        logic [CNT_W-1:0] char_count;
        logic [1:0]       ident_len;
        logic             first_is_zero;
        logic             only_digits;
        logic             failed;
    } t_state;

    typedef struct packed {
        logic valid_res;
        logic too_long;
    } t_result;

    localparam t_state ST_RESET = '{
        phase:         PH_MAJOR,
        char_count:    '0,
        ident_len:     2'd0,
        first_is_zero: 1'b0,
        only_digits:   1'b1,
        failed:        1'b0
    };

endpackage

`default_nettype wire

### hdl/svv_if.sv
// stream interfaces for the character input and the verdict output
`default_nettype none

interface svv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface

interface svv_out_if;
    logic valid;
    logic ready;
    logic valid_res;
    logic too_long;

    modport source (output valid, output valid_res, output too_long, input ready);
    modport sink   (input valid, input valid_res, input too_long, output ready);
endinterface

`default_nettype wire

### hdl/semver_string_validator.sv
// top level of the streaming semantic version string validator
// a terminating zero byte goes through the input register, then the verdict register
// throughput: one character per cycle; plain characters drain while a verdict waits,
// a terminator waits in the input register until the verdict register is free
// reset: synchronous active-low i_rst_n clears both handshake stages and the parse state
`default_nettype none

module semver_string_validator (
    input  logic      i_clk,
    input  logic      i_rst_n,
    svv_in_if.sink    i_in,
    svv_out_if.source o_out
);
    import svv_pkg::*;

    // input register
    logic       r_in_vld;
    logic [7:0] r_ch;

    // parse state, one set for the string in flight
    t_state     r_st;
    t_state     n_st;
    t_result    w_res;

    logic       w_out_free;
    logic       w_is_term;
    logic       w_consume;
    logic       w_load;

    // a plain character only updates state; the terminator needs room for its verdict
    assign w_is_term  = (r_ch == CH_NUL);
    assign w_consume  = r_in_vld && (!w_is_term || w_out_free);
    assign w_load     = w_consume && w_is_term;
    assign i_in.ready = !r_in_vld || w_consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_vld <= 1'b1;
        end else if (w_consume) begin
            r_in_vld <= 1'b0;
        end
    end

    // character payload needs no reset
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_ch <= i_in.ch;
        end
    end

    // parse state steps on every consumed request, back to reset after a verdict
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_RESET;
        end else if (w_consume) begin
            r_st <= n_st;
        end
    end

    svv_parse u_parse (
        .i_st   (r_st),
        .i_ch   (r_ch),
        .o_next (n_st),
        .o_res  (w_res)
    );

    svv_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_res   (w_res),
        .o_free  (w_out_free),
        .o_out   (o_out)
    );

`ifndef ASSERT_OFF
    // a terminator always leaves the parser in its reset state
    a_term_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_st == ST_RESET))
        else $error("parse state not cleared after verdict");

    // a loaded verdict is presented on the next cycle
    a_verdict_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> o_out.valid)
        else $error("verdict not presented after terminator");

    // an overlong string can never be reported as valid
    a_long_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.too_long) |-> !o_out.valid_res)
        else $error("overlong string reported valid");

    // the character count saturates one above the length limit
    a_count_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.char_count <= CNT_W'(MAX_LEN + 1))
        else $error("character count beyond saturation");

    // unused phase codes are never entered
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.phase <= PH_BUILD)
        else $error("parse phase out of range");
`endif

endmodule

`default_nettype wire

### hdl/svv_parse.sv
// next-state and verdict logic for one character of the version string
`default_nettype none

module svv_parse (
    input  svv_pkg::t_state  i_st,
    input  logic [7:0]       i_ch,
    output svv_pkg::t_state  o_next,
    output svv_pkg::t_result o_res
);
    import svv_pkg::*;

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_ident(input logic [7:0] c);
        is_ident = is_digit(c) || ((c >= CH_LC_A) && (c <= CH_LC_Z)) ||
                   ((c >= CH_UC_A) && (c <= CH_UC_Z)) || (c == CH_DASH);
    endfunction

    function automatic t_state take_char(input t_state s, input logic [7:0] c);
        t_state r;
        r = s;
        if (s.ident_len == 2'd0) begin
            r.first_is_zero = (c == CH_ZERO);
        end
        if (!is_digit(c)) begin
            r.only_digits = 1'b0;
        end
        if (s.ident_len < 2'd2) begin
            r.ident_len = s.ident_len + 2'd1;
        end
        return r;
    endfunction

    function automatic t_state clear_part(input t_state s);
        t_state r;
        r = s;
        r.ident_len     = 2'd0;
        r.first_is_zero = 1'b0;
        r.only_digits   = 1'b1;
        return r;
    endfunction

    logic w_part_ok;
    logic w_num_phase;
    logic w_end_phase;
    logic w_tl;

    // numeric identifiers in core and prerelease may not carry a leading zero
    assign w_num_phase = (i_st.phase <= PH_PATCH) || (i_st.phase == PH_PRE);
    assign w_part_ok   = (i_st.ident_len != 2'd0) &&
                         !(w_num_phase && i_st.only_digits &&
                           (i_st.ident_len == 2'd2) && i_st.first_is_zero);
    assign w_end_phase = (i_st.phase == PH_PATCH) || (i_st.phase == PH_PRE) ||
                         (i_st.phase == PH_BUILD);
    assign w_tl        = (i_st.char_count > CNT_W'(MAX_LEN));

    assign o_res.too_long  = w_tl;
    assign o_res.valid_res = !i_st.failed && !w_tl && (i_st.char_count != '0) &&
                             w_end_phase && w_part_ok;

    always_comb begin
        o_next = i_st;
        if (i_ch == CH_NUL) begin
            o_next = ST_RESET;
        end else begin
            if (i_st.char_count <= CNT_W'(MAX_LEN)) begin
                o_next.char_count = i_st.char_count + 1'b1;
            end
            if (!i_st.failed) begin
                if (i_st.phase <= PH_PATCH) begin
                    if (is_digit(i_ch)) begin
                        o_next = take_char(o_next, i_ch);
                    end else if (!w_part_ok) begin
                        o_next.failed = 1'b1;
                    end else begin
                        o_next = clear_part(o_next);
                        if (i_st.phase < PH_PATCH) begin
                            if (i_ch == CH_DOT) begin
                                o_next.phase = i_st.phase + 3'd1;
                            end else begin
                                o_next.failed = 1'b1;
                            end
                        end else if (i_ch == CH_DASH) begin
                            o_next.phase = PH_PRE;
                        end else if (i_ch == CH_PLUS) begin
                            o_next.phase = PH_BUILD;
                        end else begin
                            o_next.failed = 1'b1;
                        end
                    end
                end else if ((i_st.phase == PH_PRE) || (i_st.phase == PH_BUILD)) begin
                    if (is_ident(i_ch)) begin
                        o_next = take_char(o_next, i_ch);
                    end else if (!w_part_ok) begin
                        o_next.failed = 1'b1;
                    end else if (i_ch == CH_DOT) begin
                        o_next = clear_part(o_next);
                    end else if ((i_st.phase == PH_PRE) && (i_ch == CH_PLUS)) begin
                        o_next       = clear_part(o_next);
                        o_next.phase = PH_BUILD;
                    end else begin
                        o_next.failed = 1'b1;
                    end
                end else begin
                    o_next.failed = 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

### hdl/svv_out_reg.sv
// verdict output register with valid/ready handshake
`default_nettype none

module svv_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  svv_pkg::t_result i_res,
    output logic             o_free,
    svv_out_if.source        o_out
);
    import svv_pkg::*;

    logic    r_vld;
    t_result r_res;

    assign o_free          = !r_vld || o_out.ready;
    assign o_out.valid     = r_vld;
    assign o_out.valid_res = r_res.valid_res;
    assign o_out.too_long  = r_res.too_long;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_load) begin
            r_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

`default_nettype wire

### bench/tb_top.sv
// testbench for the semantic version string validator, checked against a local predictor

module tb_top;
    import svv_pkg::*;

    // run shape
    localparam int RANDOM_CHARS   = 1900;
    localparam int SEGMENT_CHARS  = 250;
    localparam int HOLD_CYCLES    = 200;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    // scoreboard: follows the parse state per accepted character and queues the verdict
    // that each terminating zero byte should produce
    class verdict_scoreboard;
        t_state  ps;
        t_result expected_verdicts[$];
        int      n_mismatch;
        int      n_verdicts;
        int      n_ok;
        int      n_long;

        function new();
            ps = ST_RESET;
        endfunction

        task report_mismatch(input string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            n_mismatch++;
        endtask

        function bit is_digit(input logic [7:0] c);
            return c >= CH_ZERO && c <= CH_NINE;
        endfunction

        function bit is_ident(input logic [7:0] c);
            return is_digit(c) || (c >= CH_LC_A && c <= CH_LC_Z) ||
                   (c >= CH_UC_A && c <= CH_UC_Z) || c == CH_DASH;
        endfunction

        function void clear_part();
            ps.ident_len     = 2'd0;
            ps.first_is_zero = 1'b0;
            ps.only_digits   = 1'b1;
        endfunction

        function void take_char(input logic [7:0] c);
            if (ps.ident_len == 2'd0) ps.first_is_zero = (c == CH_ZERO);
            if (!is_digit(c)) ps.only_digits = 1'b0;
            if (ps.ident_len != 2'd2) ps.ident_len = ps.ident_len + 2'd1;
        endfunction

        // the part just closed is non-empty and, where numbers are strict, has no leading zero
        function bit part_ok();
            if (ps.ident_len == 2'd0) return 1'b0;
            if ((ps.phase <= PH_PATCH || ps.phase == PH_PRE) &&
                ps.only_digits && ps.ident_len == 2'd2 && ps.first_is_zero)
                return 1'b0;
            return 1'b1;
        endfunction

        function void parse_char(input logic [7:0] c);
            if (ps.phase <= PH_PATCH) begin
                if (is_digit(c)) begin
                    take_char(c);
                    return;
                end
                if (!part_ok()) begin
                    ps.failed = 1'b1;
                    return;
                end
                if (ps.phase < PH_PATCH) begin
                    if (c == CH_DOT) ps.phase = ps.phase + 3'd1;
                    else ps.failed = 1'b1;
                end else if (c == CH_DASH) begin
                    ps.phase = PH_PRE;
                end else if (c == CH_PLUS) begin
                    ps.phase = PH_BUILD;
                end else begin
                    ps.failed = 1'b1;
                end
                clear_part();
                return;
            end
            if (ps.phase == PH_PRE || ps.phase == PH_BUILD) begin
                if (is_ident(c)) begin
                    take_char(c);
                    return;
                end
                if (!part_ok()) begin
                    ps.failed = 1'b1;
                    return;
                end
                if (c == CH_DOT) begin
                    clear_part();
                end else if (ps.phase == PH_PRE && c == CH_PLUS) begin
                    ps.phase = PH_BUILD;
                    clear_part();
                end else begin
                    ps.failed = 1'b1;
                end
                return;
            end
            // unused phase codes
            ps.failed = 1'b1;
        endfunction

        function void note_char(input logic [7:0] c);
            t_result v;
            if (c != CH_NUL) begin
                if (ps.char_count <= MAX_LEN) ps.char_count = ps.char_count + 1'b1;
                if (!ps.failed) parse_char(c);
            end else begin
                v.too_long  = ps.char_count > MAX_LEN;
                v.valid_res = !ps.failed && !v.too_long && ps.char_count != 0 &&
                              (ps.phase == PH_PATCH || ps.phase == PH_PRE ||
                               ps.phase == PH_BUILD) && part_ok();
                expected_verdicts.push_back(v);
                ps = ST_RESET;
            end
        endfunction

        task check_verdict(input t_result got);
            t_result want;
            if (expected_verdicts.size() == 0) begin
                report_mismatch("verdict with no string waiting");
                return;
            end
            want = expected_verdicts.pop_front();
            n_verdicts++;
            if (want.valid_res) n_ok++;
            if (want.too_long) n_long++;
            if (got.valid_res !== want.valid_res)
                report_mismatch($sformatf("verdict %0d: valid_res %b, expected %b",
                                          n_verdicts, got.valid_res, want.valid_res));
            if (got.too_long !== want.too_long)
                report_mismatch($sformatf("verdict %0d: too_long %b, expected %b",
                                          n_verdicts, got.too_long, want.too_long));
        endtask

        function int pending();
            return expected_verdicts.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    svv_in_if  in_ch();
    svv_out_if out_ch();

    semver_string_validator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    verdict_scoreboard sb;

    logic [7:0] str_buf[$];   // string being built, without its terminator
    bit         in_idle;      // sender draws gaps between requests
    bit         out_idle;     // receiver draws gaps before taking a verdict
    bit         long_hold;    // asks the receiver for one long back-pressure stretch
    int         n_sent;
    int         n_strings;
    int         idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // monitor: every accepted request feeds the predictor, every accepted verdict is checked
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) sb.note_char(in_ch.ch);
            if (out_ch.valid && out_ch.ready) begin
                got.valid_res = out_ch.valid_res;
                got.too_long  = out_ch.too_long;
                sb.check_verdict(got);
            end
        end
    end

    // watchdog: too long with nothing moving on either side means the block has hung
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: nothing accepted for %0d cycles, %0d verdicts outstanding",
                     WATCHDOG_LIMIT, sb.pending());
            $display("[semver_string_validator] ERROR");
            $finish;
        end
    end

    // receiver: random gaps per verdict, plus one long hold when asked
    initial begin
        int gap;
        out_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (long_hold) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                long_hold = 1'b0;
            end
            gap = out_idle ? $urandom_range(0, 7) : 0;
            if (gap != 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    // one request, after a random gap; valid stays high into the next request when there is none
    task automatic send_char(input logic [7:0] c);
        int gap;
        gap = in_idle ? $urandom_range(0, 7) : 0;
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.ch    <= c;
        do @(posedge i_clk); while (!in_ch.ready);
        n_sent++;
    endtask

    task automatic send_buf();
        foreach (str_buf[i]) send_char(str_buf[i]);
        send_char(CH_NUL);
        n_strings++;
    endtask

    // sender pause: let every verdict come back before going on
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    function automatic void load_text(input string text);
        str_buf = {};
        foreach (text[i]) str_buf.push_back(text[i]);
    endfunction

    function automatic logic [7:0] rand_digit();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_ident_char();
        int k;
        k = $urandom_range(0, 62);
        if (k < 10) return CH_ZERO + 8'(k);
        if (k < 36) return CH_UC_A + 8'(k - 10);
        if (k < 62) return CH_LC_A + 8'(k - 36);
        return CH_DASH;
    endfunction

    // core number: mostly well formed, sometimes a bare zero or a leading zero
    function automatic void push_number();
        int n;
        case ($urandom_range(0, 7))
            0: str_buf.push_back(CH_ZERO);
            1: begin
                str_buf.push_back(CH_ZERO);
                str_buf.push_back(rand_digit());
            end
            default: begin
                str_buf.push_back(CH_ZERO + 8'($urandom_range(1, 9)));
                n = $urandom_range(0, 3);
                repeat (n) str_buf.push_back(rand_digit());
            end
        endcase
    endfunction

    // dot-separated identifiers, numeric ones with an occasional leading zero, rarely empty
    function automatic void push_idents(input int count);
        int  len;
        bit  numeric;
        for (int i = 0; i < count; i++) begin
            if (i > 0) str_buf.push_back(CH_DOT);
            len     = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 4);
            numeric = ($urandom_range(0, 2) == 0);
            for (int j = 0; j < len; j++) begin
                if (!numeric) str_buf.push_back(rand_ident_char());
                else if (j == 0 && $urandom_range(0, 2) == 0) str_buf.push_back(CH_ZERO);
                else str_buf.push_back(rand_digit());
            end
        end
    endfunction

    // random string: well-formed versions with random content, then some mutated,
    // truncated, stretched round the length limit, or plain noise
    function automatic void make_string();
        int shape;
        int target;
        int n;
        bit has_build;
        str_buf   = {};
        has_build = 1'b0;
        shape     = $urandom_range(0, 99);
        if (shape >= 88) begin
            n = $urandom_range(0, 12);
            repeat (n) str_buf.push_back(8'($urandom_range(1, 255)));
            return;
        end
        push_number();
        str_buf.push_back(CH_DOT);
        push_number();
        str_buf.push_back(CH_DOT);
        push_number();
        if ($urandom_range(0, 1) == 1) begin
            str_buf.push_back(CH_DASH);
            push_idents($urandom_range(1, 3));
        end
        if ($urandom_range(0, 2) == 0) begin
            str_buf.push_back(CH_PLUS);
            push_idents($urandom_range(1, 3));
            has_build = 1'b1;
        end
        if (shape >= 78) begin
            // lengths right at the limit, and now and then far past it
            target = ($urandom_range(0, 3) == 0) ? $urandom_range(MAX_LEN + 2, 70)
                                                 : $urandom_range(MAX_LEN - 2, MAX_LEN + 2);
            str_buf.push_back(has_build ? CH_DOT : CH_PLUS);
            while (str_buf.size() < target) str_buf.push_back(rand_ident_char());
        end else if (shape >= 68) begin
            n = $urandom_range(0, str_buf.size() - 1);
            while (str_buf.size() > n) void'(str_buf.pop_back());
        end else if (shape >= 56) begin
            str_buf[$urandom_range(0, str_buf.size() - 1)] = 8'($urandom_range(1, 255));
        end
    endfunction

    // stimulus
    initial begin
        int start_sent;
        int next_switch;
        int segment;
        bit hold_asked;
        bit pause_done;

        sb           = new();
        in_ch.valid  <= 1'b0;
        in_ch.ch     <= CH_NUL;
        i_rst_n      <= 1'b0;
        in_idle      = 1'b1;
        out_idle     = 1'b1;
        long_hold    = 1'b0;
        n_sent       = 0;
        n_strings    = 0;
        hold_asked   = 1'b0;
        pause_done   = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty string, a full version with prerelease and build with a leading
        // zero in build, a truncated core with a leading zero, and an all-ones byte
        str_buf = {};
        send_buf();
        load_text("0.10.9-rc.1+01");
        send_buf();
        load_text("1.02");
        send_buf();
        str_buf = {8'hFF};
        send_buf();
        wait_drained();

        // random: every fourth segment runs with no idling, the others draw random idling on each side
        start_sent  = n_sent;
        next_switch = n_sent;
        segment     = 0;
        while (n_sent < start_sent + RANDOM_CHARS) begin
            if (n_sent >= next_switch) begin
                in_idle  = (segment % 4 != 0) && ($urandom_range(0, 2) != 0);
                out_idle = (segment % 4 != 0) && ($urandom_range(0, 2) != 0);
                next_switch += SEGMENT_CHARS;
                segment++;
            end
            // receiver holds off while the sender keeps going, so the block backs up
            if (!hold_asked && n_sent >= start_sent + 600) begin
                hold_asked = 1'b1;
                in_idle    = 1'b0;
                long_hold  = 1'b1;
            end
            if (!pause_done && n_sent >= start_sent + 1300) begin
                pause_done = 1'b1;
                wait_drained();
            end
            make_string();
            send_buf();
        end

        // drain: every verdict back, then a further wait of DRAIN_CYCLES for anything stray
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d verdicts never arrived", sb.pending()));

        $display("covered %0d characters in %0d strings: %0d verdicts, %0d valid, %0d too long",
                 n_sent, n_strings, sb.n_verdicts, sb.n_ok, sb.n_long);
        $display("with random gaps on both sides, one long verdict hold and drained pauses");
        if (sb.n_mismatch == 0)
            $display("[semver_string_validator] OK");
        else
            $display("[semver_string_validator] ERROR");
        $finish;
    end

endmodule
